// ----- rtl/core/vpa_pkg.sv -----
// shared types, op codes and helpers for the voice pool allocator
package vpa_pkg;

   localparam int OP_W      = 3;
   localparam int ID_W      = 32;
   localparam int BUS_W     = 2;
   localparam int CNT_OUT_W = 7;
   localparam int BUS_COUNT = 4;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [ID_W-1:0]      voice_id_type;
   typedef logic [BUS_W-1:0]     bus_type;
   typedef logic [CNT_OUT_W-1:0] count_out_type;

   localparam op_type OP_START    = 3'd0;
   localparam op_type OP_STOP     = 3'd1;
   localparam op_type OP_STOP_BUS = 3'd2;
   localparam op_type OP_ENDED    = 3'd3;
   localparam op_type OP_SWEEP    = 3'd4;
   localparam op_type OP_QUERY    = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic issue;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

   function automatic bus_type clamp_bus(bus_type b);
      bus_type r;
      r = b;
      if (int'(b) >= BUS_COUNT) r = BUS_W'(BUS_COUNT - 1);
      return r;
   endfunction

endpackage

// ----- rtl/core/vpa_req_if.sv -----
// request channel of the voice pool allocator
interface vpa_req_if;
   logic                  valid;
   logic                  ready;
   vpa_pkg::op_type       op;
   vpa_pkg::voice_id_type voice_ref;
   vpa_pkg::bus_type      voice_bus;
   logic                  is_looping;

   modport source (output valid, output op, output voice_ref, output voice_bus,
                   output is_looping, input ready);
   modport sink   (input valid, input op, input voice_ref, input voice_bus,
                   input is_looping, output ready);
endinterface

// ----- rtl/core/vpa_rsp_if.sv -----
// response channel of the voice pool allocator
interface vpa_rsp_if;
   logic                   valid;
   logic                   ready;
   vpa_pkg::voice_id_type  new_voice;
   vpa_pkg::voice_id_type  stolen_voice;
   vpa_pkg::count_out_type removed_count;
   logic                   is_playing;
   vpa_pkg::count_out_type active_count;

   modport source (output valid, output new_voice, output stolen_voice,
                   output removed_count, output is_playing, output active_count,
                   input ready);
   modport sink   (input valid, input new_voice, input stolen_voice,
                   input removed_count, input is_playing, input active_count,
                   output ready);
endinterface

// ----- rtl/core/vpa_ctrl.sv -----
// sequencing state machine of the voice pool allocator
module vpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vpa_pkg::status_type status,
   output vpa_pkg::cmd_type    cmd
);
   import vpa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_APPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (status.out_free) begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign req_ready = (state_ff == ST_IDLE) && !reset;

endmodule

// ----- rtl/core/vpa_datapath.sv -----
// slot storage, scan evaluation and result register of the voice pool allocator
module vpa_datapath #(
   parameter int VOICE_SLOTS = 96
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vpa_pkg::cmd_type        cmd,
   output vpa_pkg::status_type     status,
   input  vpa_pkg::op_type         req_op,
   input  vpa_pkg::voice_id_type   req_voice_ref,
   input  vpa_pkg::bus_type        req_voice_bus,
   input  logic                    req_is_looping,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output vpa_pkg::voice_id_type   rsp_new_voice,
   output vpa_pkg::voice_id_type   rsp_stolen_voice,
   output vpa_pkg::count_out_type  rsp_removed_count,
   output logic                    rsp_is_playing,
   output vpa_pkg::count_out_type  rsp_active_count
);
   import vpa_pkg::*;

   localparam int IW = $clog2(VOICE_SLOTS);
   localparam int CW = $clog2(VOICE_SLOTS + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(VOICE_SLOTS - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(VOICE_SLOTS);

   function automatic count_out_type to_out(logic [CW-1:0] c);
      logic [CW+CNT_OUT_W-1:0] w;
      w = {{CNT_OUT_W{1'b0}}, c};
      return w[CNT_OUT_W-1:0];
   endfunction

   // latched item
   op_type       op_ff;
   voice_id_type ref_ff;
   bus_type      bus_ff;
   logic         loop_ff;

   // slot memories
   voice_id_type slot_id_mem    [VOICE_SLOTS];
   bus_type      slot_bus_mem   [VOICE_SLOTS];
   voice_id_type slot_order_mem [VOICE_SLOTS];
   voice_id_type id_rd_ff, order_rd_ff;
   bus_type      bus_rd_ff;

   // slot flags
   logic [VOICE_SLOTS-1:0] valid_ff, valid_in;
   logic [VOICE_SLOTS-1:0] looping_ff, looping_in;
   logic [VOICE_SLOTS-1:0] ended_ff, ended_in;

   // scan
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic          eval_vld_ff;
   logic [IW-1:0] eval_idx_ff;
   logic          found_ff, found_in;
   logic [IW-1:0] target_ff, target_in;
   voice_id_type  best_age_ff, best_age_in;
   voice_id_type  victim_ff, victim_in;
   logic [CW-1:0] removed_ff, removed_in;

   // pool state
   logic [CW-1:0] active_ff, active_in;
   voice_id_type  next_id_ff, next_id_in;
   voice_id_type  start_cnt_ff, start_cnt_in;

   // result
   logic          rsp_valid_ff, rsp_valid_in;
   voice_id_type  new_voice_ff, new_voice_in;
   voice_id_type  stolen_ff, stolen_in;
   logic [CW-1:0] rsp_removed_ff, rsp_removed_in;
   logic          playing_ff, playing_in;

   logic          full;
   logic          ev_valid, ev_loop, ev_ended;
   logic          take, clr, mem_wr;
   voice_id_type  age, next_id_inc;

   assign full     = (active_ff == FULL_CNT);
   assign ev_valid = valid_ff[eval_idx_ff];
   assign ev_loop  = looping_ff[eval_idx_ff];
   assign ev_ended = ended_ff[eval_idx_ff];
   assign age      = start_cnt_ff - order_rd_ff;

   always_comb begin
      take = 1'b0;
      clr  = 1'b0;
      case (op_ff)
         OP_START: begin
            if (full) take = ev_valid && !ev_loop && (!found_ff || age > best_age_ff);
            else      take = !ev_valid && !found_ff;
         end
         OP_STOP, OP_ENDED, OP_QUERY: begin
            take = ev_valid && (ref_ff != '0) && (id_rd_ff == ref_ff) && !found_ff;
         end
         OP_STOP_BUS: clr = ev_valid && (bus_rd_ff == bus_ff);
         OP_SWEEP:    clr = ev_valid && !ev_loop && ev_ended;
         default: begin
            take = 1'b0;
            clr  = 1'b0;
         end
      endcase
      take = take && eval_vld_ff;
      clr  = clr && eval_vld_ff;
   end

   assign next_id_inc = next_id_ff + 1'b1;

   always_comb begin
      scan_idx_in    = scan_idx_ff;
      found_in       = found_ff;
      target_in      = target_ff;
      best_age_in    = best_age_ff;
      victim_in      = victim_ff;
      removed_in     = removed_ff;
      valid_in       = valid_ff;
      looping_in     = looping_ff;
      ended_in       = ended_ff;
      active_in      = active_ff;
      next_id_in     = next_id_ff;
      start_cnt_in   = start_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      new_voice_in   = new_voice_ff;
      stolen_in      = stolen_ff;
      rsp_removed_in = rsp_removed_ff;
      playing_in     = playing_ff;
      mem_wr         = 1'b0;

      if (cmd.load) begin
         scan_idx_in = '0;
         found_in    = 1'b0;
         best_age_in = '0;
         removed_in  = '0;
      end
      if (cmd.issue) scan_idx_in = scan_idx_ff + 1'b1;
      if (take) begin
         found_in    = 1'b1;
         target_in   = eval_idx_ff;
         best_age_in = age;
         victim_in   = id_rd_ff;
      end
      if (clr) begin
         valid_in[eval_idx_ff] = 1'b0;
         removed_in            = removed_ff + 1'b1;
      end

      if (cmd.apply) begin
         rsp_valid_in   = 1'b1;
         new_voice_in   = '0;
         stolen_in      = '0;
         rsp_removed_in = '0;
         playing_in     = 1'b0;
         case (op_ff)
            OP_START: begin
               if (found_ff) begin
                  mem_wr                = 1'b1;
                  valid_in[target_ff]   = 1'b1;
                  looping_in[target_ff] = loop_ff;
                  ended_in[target_ff]   = 1'b0;
                  new_voice_in          = next_id_ff;
                  next_id_in            = (next_id_inc == '0) ? ID_W'(1) : next_id_inc;
                  start_cnt_in          = start_cnt_ff + 1'b1;
                  if (full) begin
                     stolen_in      = victim_ff;
                     rsp_removed_in = CW'(1);
                  end else begin
                     active_in = active_ff + 1'b1;
                  end
               end
            end
            OP_STOP: begin
               if (found_ff) begin
                  valid_in[target_ff] = 1'b0;
                  rsp_removed_in      = CW'(1);
                  active_in           = active_ff - 1'b1;
               end
            end
            OP_STOP_BUS, OP_SWEEP: begin
               rsp_removed_in = removed_ff;
               active_in      = active_ff - removed_ff;
            end
            OP_ENDED: begin
               if (found_ff) ended_in[target_ff] = 1'b1;
            end
            OP_QUERY: begin
               playing_in = found_ff && !ended_ff[target_ff];
            end
            default: begin
               playing_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         eval_vld_ff  <= 1'b0;
         active_ff    <= '0;
         next_id_ff   <= ID_W'(1);
         start_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         eval_vld_ff  <= cmd.issue;
         active_ff    <= active_in;
         next_id_ff   <= next_id_in;
         start_cnt_ff <= start_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         ref_ff  <= req_voice_ref;
         bus_ff  <= clamp_bus(req_voice_bus);
         loop_ff <= req_is_looping;
      end
      scan_idx_ff    <= scan_idx_in;
      eval_idx_ff    <= scan_idx_ff;
      found_ff       <= found_in;
      target_ff      <= target_in;
      best_age_ff    <= best_age_in;
      victim_ff      <= victim_in;
      removed_ff     <= removed_in;
      looping_ff     <= looping_in;
      ended_ff       <= ended_in;
      new_voice_ff   <= new_voice_in;
      stolen_ff      <= stolen_in;
      rsp_removed_ff <= rsp_removed_in;
      playing_ff     <= playing_in;
   end

   // slot memories: one read port for the scan, one write port for placement
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         id_rd_ff    <= slot_id_mem[scan_idx_ff];
         bus_rd_ff   <= slot_bus_mem[scan_idx_ff];
         order_rd_ff <= slot_order_mem[scan_idx_ff];
      end
      if (mem_wr) begin
         slot_id_mem[target_ff]    <= next_id_ff;
         slot_bus_mem[target_ff]   <= bus_ff;
         slot_order_mem[target_ff] <= start_cnt_ff;
      end
   end

   assign status.scan_last = (scan_idx_ff == LAST_IDX);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_voice     = new_voice_ff;
   assign rsp_stolen_voice  = stolen_ff;
   assign rsp_removed_count = to_out(rsp_removed_ff);
   assign rsp_is_playing    = playing_ff;
   assign rsp_active_count  = to_out(active_ff);

endmodule

// ----- rtl/core/voice_pool_allocator.sv -----
// Voice pool allocator: a pool of VOICE_SLOTS voice slots with oldest one-shot
// voice stealing. Each request (start, stop, stop bus, voice ended, sweep,
// query) is taken only while the block is idle and produces exactly one
// response. The response follows a scan of all VOICE_SLOTS slots, and it waits
// while the response register still holds its previous response: the slot
// memories have one read port and are scanned one slot per cycle for every
// request. The block is ready again in the cycle its response appears. A new
// request can be taken while the previous response still waits for its
// transfer.
module voice_pool_allocator #(
   parameter int VOICE_SLOTS = 96
) (
   input logic       clock,
   input logic       reset,
   vpa_req_if.sink   req_chan,
   vpa_rsp_if.source rsp_chan
);
   import vpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vpa_datapath #(
      .VOICE_SLOTS (VOICE_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (req_chan.op),
      .req_voice_ref     (req_chan.voice_ref),
      .req_voice_bus     (req_chan.voice_bus),
      .req_is_looping    (req_chan.is_looping),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_new_voice     (rsp_chan.new_voice),
      .rsp_stolen_voice  (rsp_chan.stolen_voice),
      .rsp_removed_count (rsp_chan.removed_count),
      .rsp_is_playing    (rsp_chan.is_playing),
      .rsp_active_count  (rsp_chan.active_count)
   );

endmodule

// ----- rtl/core/vpa_checker.sv -----
// port-level checks of the voice pool allocator and their binding
module vpa_checker #(
   parameter int VOICE_SLOTS = 96
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input vpa_pkg::voice_id_type  new_voice,
   input vpa_pkg::voice_id_type  stolen_voice,
   input vpa_pkg::count_out_type removed_count,
   input logic                   is_playing,
   input vpa_pkg::count_out_type active_count
);
   import vpa_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_voice)
         && $stable(stolen_voice) && $stable(removed_count)
         && $stable(is_playing) && $stable(active_count))
      else $error("response changed while stalled");

   // one request in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in work");

   // a steal always comes with a new voice and one removal
   a_steal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stolen_voice != '0 |-> new_voice != '0 && removed_count == 7'd1)
      else $error("steal without placement");

   // the reported pool count never exceeds its slots (checked for pools up to 127 slots)
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (VOICE_SLOTS > 127) || (int'(active_count) <= VOICE_SLOTS))
      else $error("active count beyond pool size");

   // a playing answer changes nothing
   a_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_playing |-> new_voice == '0 && removed_count == '0)
      else $error("query result mixed with pool change");

endmodule

bind voice_pool_allocator vpa_checker #(
   .VOICE_SLOTS (VOICE_SLOTS)
) u_vpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .new_voice     (rsp_chan.new_voice),
   .stolen_voice  (rsp_chan.stolen_voice),
   .removed_count (rsp_chan.removed_count),
   .is_playing    (rsp_chan.is_playing),
   .active_count  (rsp_chan.active_count)
);
